// ===== design/cgl_pkg.sv =====
package cgl_pkg;

  localparam int INT_W      = 14;
  localparam int COLOR_W    = 24;
  localparam int CHAN_W     = 8;
  localparam int NUM_CH     = 3;
  localparam int COUNT_W    = 3;
  localparam int LEVEL_W    = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int WEIGHT_W   = 14;
  localparam int NUM_W      = 22;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_0     = 3'd1;

  localparam logic [WEIGHT_W-1:0] ALPHA_ONE   = 14'd10000;
  localparam logic [WEIGHT_W-1:0] LEVEL_SCALE = 14'd100;
  localparam logic [CHAN_W-1:0]   CHAN_FULL   = 8'hFF;

  typedef logic [NUM_CH-1:0][CHAN_W-1:0] rgb_t;

  typedef struct packed {
    rgb_t                c0;
    rgb_t                c1;
    logic [WEIGHT_W-1:0] w0;
    logic [WEIGHT_W-1:0] w1;
    logic [WEIGHT_W-1:0] den;
  } job_t;

endpackage

// ===== design/cgl_ifs.sv =====
interface cgl_in_if;
  logic                       valid;
  logic                       ready;
  logic [cgl_pkg::INT_W-1:0]  intensity;
  modport source (output valid, output intensity, input ready);
  modport sink (input valid, input intensity, output ready);
endinterface

interface cgl_out_if;
  logic                        valid;
  logic                        ready;
  logic [cgl_pkg::COLOR_W-1:0] color;
  modport source (output valid, output color, input ready);
  modport sink (input valid, input color, output ready);
endinterface

interface cgl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cgl_pkg::CFG_IDX_W-1:0]  index;
  logic [cgl_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/cgl_front.sv =====
module cgl_front #(
  parameter int MAX_POINTS = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  cgl_in_if.sink        in_ch,
  cgl_cfg_if.sink       cfg_ch,
  output cgl_pkg::job_t job,
  output logic          job_push,
  input  logic          q_full
);

  localparam int PIDX_W = $clog2(MAX_POINTS);
  localparam logic [cgl_pkg::COUNT_W-1:0] MAX_N = cgl_pkg::COUNT_W'(MAX_POINTS);

  logic [cgl_pkg::COUNT_W-1:0]    count_r;
  logic [cgl_pkg::CFG_DATA_W-1:0] point_r [MAX_POINTS];

  logic [cgl_pkg::WEIGHT_W-1:0] alpha;
  logic [cgl_pkg::COUNT_W-1:0]  n;
  logic [cgl_pkg::WEIGHT_W-1:0] lvl [MAX_POINTS];
  logic [MAX_POINTS-1:0]        hit;
  logic [MAX_POINTS-1:0]        eq;
  logic [MAX_POINTS-1:0]        last_oh;
  logic [MAX_POINTS-1:0]        first_oh;
  logic [MAX_POINTS-1:0]        sel_oh;
  logic [MAX_POINTS-1:0]        prev_oh;
  logic                         found;
  logic                         interp;
  cgl_pkg::rgb_t                c_sel;
  cgl_pkg::rgb_t                c_prev;
  logic [cgl_pkg::WEIGHT_W-1:0] lvl_sel;
  logic [cgl_pkg::WEIGHT_W-1:0] lvl_prev;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int g = 0; g < MAX_POINTS; g++) begin
        point_r[g] <= '0;
      end
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == cgl_pkg::REG_POINT_COUNT) begin
        count_r <= cfg_ch.data[cgl_pkg::COUNT_W-1:0];
      end else if (cgl_pkg::CFG_IDX_W'(cfg_ch.index - cgl_pkg::REG_POINT_0) < MAX_N) begin
        point_r[PIDX_W'(cfg_ch.index - cgl_pkg::REG_POINT_0)] <= cfg_ch.data;
      end
    end
  end

  assign alpha = (in_ch.intensity > cgl_pkg::ALPHA_ONE) ? cgl_pkg::ALPHA_ONE
                                                        : in_ch.intensity;
  assign n = (count_r > MAX_N) ? MAX_N : count_r;

  always_comb begin
    for (int g = 0; g < MAX_POINTS; g++) begin
      lvl[g] = cgl_pkg::WEIGHT_W'(point_r[g][cgl_pkg::CFG_DATA_W-1:cgl_pkg::COLOR_W])
               * cgl_pkg::LEVEL_SCALE;
      hit[g] = (cgl_pkg::COUNT_W'(g) < n) && (alpha <= lvl[g]);
      eq[g] = (alpha == lvl[g]);
      last_oh[g] = (cgl_pkg::COUNT_W'(g) == cgl_pkg::COUNT_W'(n - 1'b1));
    end
  end

  assign first_oh = hit & (~hit + 1'b1);
  assign found    = |hit;
  assign sel_oh   = found ? first_oh : last_oh;
  assign prev_oh  = sel_oh >> 1;
  assign interp   = found && !(|(first_oh & eq)) && !first_oh[0];

  always_comb begin
    c_sel    = '0;
    c_prev   = '0;
    lvl_sel  = '0;
    lvl_prev = '0;
    for (int g = 0; g < MAX_POINTS; g++) begin
      if (sel_oh[g]) begin
        c_sel   = c_sel | cgl_pkg::rgb_t'(point_r[g][cgl_pkg::COLOR_W-1:0]);
        lvl_sel = lvl_sel | lvl[g];
      end
      if (prev_oh[g]) begin
        c_prev   = c_prev | cgl_pkg::rgb_t'(point_r[g][cgl_pkg::COLOR_W-1:0]);
        lvl_prev = lvl_prev | lvl[g];
      end
    end
  end

  // Every case is mapped onto one blend (c1*w1 + c0*w0) / den.
  always_comb begin
    if (n == '0) begin
      job.c0  = cgl_pkg::rgb_t'({cgl_pkg::NUM_CH{cgl_pkg::CHAN_FULL}});
      job.c1  = cgl_pkg::rgb_t'({cgl_pkg::NUM_CH{cgl_pkg::CHAN_FULL}});
      job.w0  = '0;
      job.w1  = alpha;
      job.den = cgl_pkg::ALPHA_ONE;
    end else if (interp) begin
      job.c0  = c_prev;
      job.c1  = c_sel;
      job.w0  = lvl_sel - alpha;
      job.w1  = alpha - lvl_prev;
      job.den = lvl_sel - lvl_prev;
    end else begin
      job.c0  = c_sel;
      job.c1  = c_sel;
      job.w0  = '0;
      job.w1  = cgl_pkg::WEIGHT_W'(1);
      job.den = cgl_pkg::WEIGHT_W'(1);
    end
  end

  assign in_ch.ready = !q_full;
  assign job_push    = in_ch.valid && !q_full;

`ifndef NO_ASSERTIONS
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> job.den != '0)
    else $error("front produced a word with a zero divisor");
`endif

endmodule

// ===== design/cgl_queue.sv =====
module cgl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  cgl_pkg::job_t push_data,
  input  logic          push,
  output logic          full,
  output cgl_pkg::job_t pop_data,
  output logic          pop_valid,
  input  logic          pop_ready
);

  localparam int DEPTH = cgl_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cgl_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == CNT_W'($past(cnt_r) + 1'b1))
    else $error("queue fill count missed a push");
`endif

endmodule

// ===== design/cgl_back.sv =====
module cgl_back (
  input  logic          clk,
  input  logic          rst_n,
  input  cgl_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_ready,
  cgl_out_if.source     out_ch
);

  localparam int DIV_STEPS = cgl_pkg::CHAN_W;

  typedef logic [cgl_pkg::NUM_CH-1:0][cgl_pkg::NUM_W-1:0] num3_t;

  logic                         advance;
  logic                         prod_vld_r;
  num3_t                        prod0_r;
  num3_t                        prod1_r;
  logic [cgl_pkg::WEIGHT_W-1:0] prod_den_r;
  logic [DIV_STEPS:0]           vld_r;
  num3_t                        rem_r [0:DIV_STEPS-1];
  logic [cgl_pkg::WEIGHT_W-1:0] den_r [0:DIV_STEPS-1];
  cgl_pkg::rgb_t                q_r   [1:DIV_STEPS];

  assign advance   = !vld_r[DIV_STEPS] || out_ch.ready;
  assign job_ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      vld_r      <= '0;
    end else if (advance) begin
      prod_vld_r <= job_valid;
      vld_r      <= {vld_r[DIV_STEPS-1:0], prod_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int ch = 0; ch < cgl_pkg::NUM_CH; ch++) begin
        prod0_r[ch]  <= cgl_pkg::NUM_W'(job.c0[ch]) * cgl_pkg::NUM_W'(job.w0);
        prod1_r[ch]  <= cgl_pkg::NUM_W'(job.c1[ch]) * cgl_pkg::NUM_W'(job.w1);
        rem_r[0][ch] <= prod0_r[ch] + prod1_r[ch];
      end
      prod_den_r <= job.den;
      den_r[0]   <= prod_den_r;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    logic [cgl_pkg::NUM_W-1:0] shifted;
    cgl_pkg::rgb_t             q_in;
    cgl_pkg::rgb_t             q_nxt;
    num3_t                     rem_nxt;

    if (s == 0) begin : g_first
      assign q_in = '0;
    end else begin : g_rest
      assign q_in = q_r[s];
    end

    assign shifted = cgl_pkg::NUM_W'(den_r[s]) << (DIV_STEPS - 1 - s);

    always_comb begin
      for (int ch = 0; ch < cgl_pkg::NUM_CH; ch++) begin
        if (rem_r[s][ch] >= shifted) begin
          rem_nxt[ch] = rem_r[s][ch] - shifted;
          q_nxt[ch]   = {q_in[ch][cgl_pkg::CHAN_W-2:0], 1'b1};
        end else begin
          rem_nxt[ch] = rem_r[s][ch];
          q_nxt[ch]   = {q_in[ch][cgl_pkg::CHAN_W-2:0], 1'b0};
        end
      end
    end

    if (s < DIV_STEPS - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (advance) begin
          rem_r[s+1] <= rem_nxt;
          den_r[s+1] <= den_r[s];
          q_r[s+1]   <= q_nxt;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (advance) begin
          q_r[s+1] <= q_nxt;
        end
      end
    end
  end

  assign out_ch.valid = vld_r[DIV_STEPS];
  assign out_ch.color = q_r[DIV_STEPS];

`ifndef NO_ASSERTIONS
  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> (rem_r[0][0] < (cgl_pkg::NUM_W'(den_r[0]) << cgl_pkg::CHAN_W))
              && (rem_r[0][1] < (cgl_pkg::NUM_W'(den_r[0]) << cgl_pkg::CHAN_W))
              && (rem_r[0][2] < (cgl_pkg::NUM_W'(den_r[0]) << cgl_pkg::CHAN_W)))
    else $error("blend numerator would overflow an 8-bit quotient");
`endif

endmodule

// ===== design/color_gradient_lookup_top.sv =====
// Channel   Dir  Payload                         Handshake
// in_ch     in   intensity[13:0]                 valid/ready
// out_ch    out  color[23:0] (r 23:16, g 15:8)   valid/ready
// cfg_ch    in   index[2:0], data[30:0]          valid/ready, ready always high
//
// One word per clock in steady state while out_ch is ready.
// The front classifies a word combinationally and pushes it into a two-entry queue; the back runs it
// through a multiply stage, a sum stage and eight restoring divide stages.
// Synchronous active-low reset clears the registers, the queue and the pipeline.
// An output stall freezes the back; the front keeps taking words until the queue fills.
module color_gradient_lookup_top #(
  parameter int MAX_POINTS = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  cgl_in_if.sink     in_ch,
  cgl_out_if.source  out_ch,
  cgl_cfg_if.sink    cfg_ch
);

  cgl_pkg::job_t front_job;
  logic          front_push;
  logic          q_full;
  cgl_pkg::job_t q_job;
  logic          q_valid;
  logic          back_ready;

  cgl_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .job      (front_job),
    .job_push (front_push),
    .q_full   (q_full)
  );

  cgl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_data (front_job),
    .push      (front_push),
    .full      (q_full),
    .pop_data  (q_job),
    .pop_valid (q_valid),
    .pop_ready (back_ready)
  );

  cgl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (q_job),
    .job_valid (q_valid),
    .job_ready (back_ready),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import cgl_pkg::*;

  localparam int NUM_POINTS   = 7;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_WAIT  = 14;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 3000;
  localparam int PHASES       = 12;
  localparam int PHASE_WORDS  = 86;

  class color_scoreboard;
    logic [COUNT_W-1:0]    point_count;
    logic [CFG_DATA_W-1:0] points [NUM_POINTS];
    logic [COLOR_W-1:0]    expected_colors [$];
    int                    failures;

    function new();
      point_count = '0;
      foreach (points[i]) points[i] = '0;
      failures = 0;
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == REG_POINT_COUNT) begin
        point_count = data[COUNT_W-1:0];
      end else begin
        points[index - REG_POINT_0] = data;
      end
    endfunction

    function logic [COLOR_W-1:0] predict_color(logic [INT_W-1:0] raw);
      int unsigned a, lv, lo, num, c0, c1;
      logic [COLOR_W-1:0] mixed;
      a = (raw > ALPHA_ONE) ? ALPHA_ONE : raw;
      if (point_count == 0) begin
        num = (CHAN_FULL * a) / ALPHA_ONE;
        return {NUM_CH{num[CHAN_W-1:0]}};
      end
      if (point_count == 1) return points[0][COLOR_W-1:0];
      for (int g = 0; g < point_count; g++) begin
        lv = points[g][CFG_DATA_W-1:COLOR_W] * LEVEL_SCALE;
        if (a == lv) return points[g][COLOR_W-1:0];
        if (a < lv) begin
          if (g == 0) return points[0][COLOR_W-1:0];
          lo = points[g-1][CFG_DATA_W-1:COLOR_W] * LEVEL_SCALE;
          for (int ch = 0; ch < NUM_CH; ch++) begin
            c0 = points[g-1][CHAN_W*ch +: CHAN_W];
            c1 = points[g][CHAN_W*ch +: CHAN_W];
            num = (c1 * (a - lo) + c0 * (lv - a)) / (lv - lo);
            mixed[CHAN_W*ch +: CHAN_W] = num[CHAN_W-1:0];
          end
          return mixed;
        end
      end
      return points[point_count - 1][COLOR_W-1:0];
    endfunction

    function void note_intensity(logic [INT_W-1:0] raw);
      expected_colors.insert(expected_colors.size(), predict_color(raw));
    endfunction

    function void check_color(logic [COLOR_W-1:0] got);
      logic [COLOR_W-1:0] want;
      if (expected_colors.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected color word %06h", got);
        return;
      end
      want = expected_colors.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) $display("color mismatch: expected %06h, got %06h", want, got);
      end
    endfunction

    function int pending();
      return expected_colors.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  cgl_in_if  in_if();
  cgl_out_if out_if();
  cgl_cfg_if cfg_if();

  color_gradient_lookup_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  color_scoreboard sb = new();

  logic [COUNT_W-1:0]    table_count;
  logic [CFG_DATA_W-1:0] table_points [NUM_POINTS];
  bit source_idling = 1'b1;
  bit sink_idling   = 1'b1;
  bit long_hold_req = 1'b0;
  int stuck_cycles  = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_if.valid && in_if.ready) sb.note_intensity(in_if.intensity);
      if (out_if.valid && out_if.ready) sb.check_color(out_if.color);
      if (cfg_if.valid && cfg_if.ready) sb.apply_register(cfg_if.index, cfg_if.data);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (!sink_idling) begin
        out_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic offer_intensity(input logic [INT_W-1:0] value);
    in_if.valid <= 1'b1;
    in_if.intensity <= value;
    do @(posedge clk); while (!in_if.ready);
    if (source_idling && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic quiet_input();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    quiet_input();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic program_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_table(input logic [CFG_DATA_W-1:0] count_word);
    program_register(REG_POINT_COUNT, count_word);
    for (int i = 0; i < NUM_POINTS; i++) begin
      program_register(CFG_IDX_W'(REG_POINT_0 + i), table_points[i]);
    end
  endtask

  task automatic random_table(input int phase);
    int lvl;
    bit scrambled;
    lvl = $urandom_range(0, 10);
    scrambled = ($urandom_range(0, 3) == 0);
    if (phase == 0) table_count = '0;
    else if (phase == 1 || phase == 2) table_count = COUNT_W'(NUM_POINTS);
    else table_count = COUNT_W'($urandom_range(0, NUM_POINTS));
    for (int i = 0; i < NUM_POINTS; i++) begin
      if (phase == 2) begin
        table_points[i] = '1;
      end else if (scrambled) begin
        table_points[i] = CFG_DATA_W'($urandom);
      end else begin
        table_points[i] = {LEVEL_W'(lvl), COLOR_W'($urandom)};
        lvl += $urandom_range(1, 14);
      end
    end
    program_table({(CFG_DATA_W - COUNT_W)'($urandom), table_count});
  endtask

  function automatic logic [INT_W-1:0] pick_intensity();
    int kind;
    int unsigned near;
    kind = $urandom_range(0, 9);
    if (kind < 2) return INT_W'($urandom);
    if (kind < 4) begin
      near = table_points[$urandom_range(0, NUM_POINTS - 1)][CFG_DATA_W-1:COLOR_W] * LEVEL_SCALE
             + $urandom_range(0, 2);
      return INT_W'((near == 0) ? 0 : near - 1);
    end
    return INT_W'($urandom_range(0, ALPHA_ONE));
  endfunction

  task automatic send_list(input logic [INT_W-1:0] values [$]);
    foreach (values[i]) offer_intensity(values[i]);
    settle();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.intensity <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    foreach (table_points[i]) table_points[i] = '0;
    table_count = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Gray scale straight out of reset, including saturated alphas.
    send_list('{14'd0, 14'd39, 14'd40, 14'd9999, 14'd10000, 14'd10001, 14'd16383});

    // A single point returns its own color whatever the alpha.
    table_count = 3'd1;
    table_points[0] = {7'd50, 24'h123456};
    program_table(31'(table_count));
    send_list('{14'd0, 14'd16383});

    // Sorted table: exact matches, interpolation and clamping above the last point.
    table_count = 3'd3;
    table_points[0] = {7'd0, 24'h000000};
    table_points[1] = {7'd50, 24'hFFFFFF};
    table_points[2] = {7'd100, 24'h80FF01};
    program_table(31'(table_count));
    send_list('{14'd0, 14'd1, 14'd2500, 14'd5000, 14'd7499, 14'd10000, 14'd12345});

    // Full table with duplicate and unsorted levels and a level above 100.
    table_count = 3'd7;
    table_points[0] = {7'd30, 24'h0A0B0C};
    table_points[1] = {7'd30, 24'hFF0000};
    table_points[2] = {7'd10, 24'h00FF00};
    table_points[3] = {7'd60, 24'h0000FF};
    table_points[4] = 31'h7FFFFFFF;
    table_points[5] = {7'd90, 24'h000000};
    table_points[6] = {7'd100, 24'h808080};
    program_table(31'(table_count));
    send_list('{14'd1000, 14'd3000, 14'd4500, 14'd9000, 14'd16383});

    for (int p = 0; p < PHASES; p++) begin
      if (p >= PHASES - 2) begin
        source_idling = 1'b0;
        sink_idling = 1'b0;
      end
      random_table(p);
      if (p == 5) long_hold_req = 1'b1;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 7 && i == PHASE_WORDS / 2) settle();
        offer_intensity(pick_intensity());
      end
      settle();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/cgl_pkg.sv
design/cgl_ifs.sv
design/cgl_front.sv
design/cgl_queue.sv
design/cgl_back.sv
design/color_gradient_lookup_top.sv
tb/sv/tb.sv
